/* hdl/rbvi_pkg.sv */
// Shared types, codes and helper functions for the rigid-body velocity integrator.
// Used by rbvi_ctrl, rbvi_datapath, the top level and the checker. No dependencies.
package rbvi_pkg;

    localparam int DT_BITS = 16;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic [15:0]        frame_time;
        logic               on_ground;
        logic signed [31:0] pos_in_x;
        logic signed [31:0] pos_in_y;
        logic signed [31:0] pos_in_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pos_out_x;
        logic signed [31:0] pos_out_y;
        logic signed [31:0] pos_out_z;
        logic signed [31:0] total_vel_x;
        logic signed [31:0] total_vel_y;
        logic signed [31:0] total_vel_z;
    } out_item_t;

    typedef enum logic [2:0] {
        REG_BODY_MASS      = 3'd0,
        REG_MIN_WALK_SPEED = 3'd1,
        REG_MAX_WALK_SPEED = 3'd2,
        REG_FRICTION_DECEL = 3'd3,
        REG_GRAVITY_ACCEL  = 3'd4,
        REG_MAX_FALL_SPEED = 3'd5,
        REG_JUMP_SPEED     = 3'd6,
        REG_GRAVITY_ENABLE = 3'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_JUMP,
        OP_MUL,
        OP_SHIFT,
        OP_DIV_START,
        OP_WB,
        OP_WADD,
        OP_SPD,
        OP_GSUB,
        OP_FIN,
        OP_SUM_CLR,
        OP_SQ,
        OP_SUM_ADD,
        OP_SQRT_START,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [3:0] {
        JOB_ACCEL,
        JOB_DV,
        JOB_AIR,
        JOB_MAXC,
        JOB_MINC,
        JOB_FRIC,
        JOB_DEC,
        JOB_GRAV,
        JOB_FALL,
        JOB_POS
    } job_t;

    typedef enum logic [1:0] {
        VEC_WALK,
        VEC_FALL,
        VEC_FORCE
    } vec_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MD_MUL,
        S_MD_DIV,
        S_MD_WAIT,
        S_MD_WB,
        S_LEN_CLR,
        S_LEN_MUL,
        S_LEN_ACC,
        S_LEN_SQRT,
        S_LEN_WAIT,
        S_ACCEL,
        S_DV,
        S_AIR,
        S_WADD,
        S_MAXC0,
        S_MAXC,
        S_MIN0,
        S_MIN1,
        S_MINC,
        S_FRIC0,
        S_FRIC1,
        S_FRIC2,
        S_FRIC,
        S_GRAV0,
        S_GRAV1,
        S_GRAV2,
        S_GRAV3,
        S_FALL,
        S_FIN,
        S_POS,
        S_EMIT
    } state_t;

    typedef struct packed {
        dp_op_t     op;
        job_t       job;
        vec_t       vec;
        logic [1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic airborne;
        logic acc_nz;
        logic force_nz;
        logic min_on;
        logic len_zero;
        logic len_lt_ten;
        logic max_walk_hit;
        logic fall_cap_on;
        logic max_fall_hit;
        logic div_busy;
        logic sqrt_busy;
        logic out_busy;
    } dp_status_t;

    // Jobs whose divisor is a power of two finish with a shift.
    function automatic logic job_is_shift(input job_t j);
        logic r;
        case (j)
            JOB_DV, JOB_AIR, JOB_DEC, JOB_GRAV, JOB_POS: r = 1'b1;
            default:                                     r = 1'b0;
        endcase
        return r;
    endfunction

    // Jobs that walk over the three components.
    function automatic logic job_is_vec(input job_t j);
        logic r;
        case (j)
            JOB_ACCEL, JOB_MAXC, JOB_MINC, JOB_FRIC, JOB_FALL, JOB_POS: r = 1'b1;
            default:                                                      r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31])
            return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        return s[31:0];
    endfunction

    // Apply a sign to a magnitude and saturate to 32 bits.
    function automatic logic signed [31:0] mag_to_s32(input logic neg, input logic [63:0] r);
        logic signed [31:0] v;
        if (!neg)
            v = (r > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : r[31:0];
        else
            v = (r > 64'h8000_0000) ? 32'sh8000_0000 : (~r[31:0] + 32'd1);
        return v;
    endfunction

    function automatic logic [30:0] sat_cfg(input logic [63:0] v);
        return (v > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : v[30:0];
    endfunction

endpackage

/* hdl/rigid_body_velocity_integrator.sv */
// Top level of the rigid-body velocity integrator: joins sequencer and datapath.
// Depends on rbvi_pkg, rbvi_ctrl, rbvi_datapath.
//
//  channel  | direction | handshake              | beat
//  ---------+-----------+------------------------+---------------------------
//  item     | in        | item_valid/item_stall  | rbvi_pkg::in_item_t
//  result   | out       | result_valid/result_st.| rbvi_pkg::out_item_t
//  cfg      | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// A jump beat is taken without holding the input. A tick beat runs, for each
// scaled component, a multiply, then a divide on the one-bit-per-cycle divider
// or a shift, then a write back; each vector length is a sum of squares and a
// pass through the square-root unit.
// item_stall is high while a tick is in work; a finished result sits in the output
// register, so the next beat is taken while it waits on result_stall.
// Reset is asynchronous; there is no clearing pass after it.
module rigid_body_velocity_integrator #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  rbvi_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output rbvi_pkg::out_item_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    rbvi_pkg::dp_cmd_t    cmd;
    rbvi_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    rbvi_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_mode  (item.mode),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    rbvi_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .item         (item),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

/* hdl/rbvi_ctrl.sv */
// Sequencer for the integrator: walks each tick through its steps and drives
// datapath commands. Depends on rbvi_pkg.
module rbvi_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 item_mode,
    output logic                 item_stall,
    input  rbvi_pkg::dp_status_t status,
    output rbvi_pkg::dp_cmd_t    cmd
);

    rbvi_pkg::state_t state_reg, state_next;
    rbvi_pkg::state_t ret_reg, ret_next;
    rbvi_pkg::job_t   job_reg, job_next;
    rbvi_pkg::vec_t   vec_reg, vec_next;
    logic [1:0]       idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rbvi_pkg::S_IDLE;
            ret_reg   <= rbvi_pkg::S_IDLE;
            job_reg   <= rbvi_pkg::JOB_ACCEL;
            vec_reg   <= rbvi_pkg::VEC_WALK;
            idx_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            job_reg   <= job_next;
            vec_reg   <= vec_next;
            idx_reg   <= idx_next;
        end
    end

    assign item_stall = (state_reg != rbvi_pkg::S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        job_next   = job_reg;
        vec_next   = vec_reg;
        idx_next   = idx_reg;
        cmd.op     = rbvi_pkg::OP_NONE;
        cmd.job    = job_reg;
        cmd.vec    = vec_reg;
        cmd.idx    = idx_reg;

        case (state_reg)
            rbvi_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    idx_next = 2'd0;
                    if (item_mode)
                        cmd.op = rbvi_pkg::OP_JUMP;
                    else
                    begin
                        cmd.op     = rbvi_pkg::OP_LOAD;
                        state_next = rbvi_pkg::S_ACCEL;
                    end
                end
            end

            // multiply, then divide or shift, then write back
            rbvi_pkg::S_MD_MUL:
            begin
                cmd.op     = rbvi_pkg::OP_MUL;
                state_next = rbvi_pkg::S_MD_DIV;
            end
            rbvi_pkg::S_MD_DIV:
            begin
                if (rbvi_pkg::job_is_shift(job_reg))
                begin
                    cmd.op     = rbvi_pkg::OP_SHIFT;
                    state_next = rbvi_pkg::S_MD_WB;
                end
                else
                begin
                    cmd.op     = rbvi_pkg::OP_DIV_START;
                    state_next = rbvi_pkg::S_MD_WAIT;
                end
            end
            rbvi_pkg::S_MD_WAIT:
            begin
                if (!status.div_busy)
                    state_next = rbvi_pkg::S_MD_WB;
            end
            rbvi_pkg::S_MD_WB:
            begin
                cmd.op = rbvi_pkg::OP_WB;
                if (rbvi_pkg::job_is_vec(job_reg))
                    idx_next = idx_reg + 2'd1;
                state_next = ret_reg;
            end

            // vector length: sum of squares, then square root
            rbvi_pkg::S_LEN_CLR:
            begin
                cmd.op     = rbvi_pkg::OP_SUM_CLR;
                idx_next   = 2'd0;
                state_next = rbvi_pkg::S_LEN_MUL;
            end
            rbvi_pkg::S_LEN_MUL:
            begin
                cmd.op     = rbvi_pkg::OP_SQ;
                state_next = rbvi_pkg::S_LEN_ACC;
            end
            rbvi_pkg::S_LEN_ACC:
            begin
                cmd.op = rbvi_pkg::OP_SUM_ADD;
                if (idx_reg == 2'd2)
                begin
                    idx_next   = 2'd0;
                    state_next = rbvi_pkg::S_LEN_SQRT;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = rbvi_pkg::S_LEN_MUL;
                end
            end
            rbvi_pkg::S_LEN_SQRT:
            begin
                cmd.op     = rbvi_pkg::OP_SQRT_START;
                state_next = rbvi_pkg::S_LEN_WAIT;
            end
            rbvi_pkg::S_LEN_WAIT:
            begin
                if (!status.sqrt_busy)
                    state_next = ret_reg;
            end

            rbvi_pkg::S_ACCEL:
            begin
                if (idx_reg == 2'd3)
                begin
                    idx_next   = 2'd0;
                    state_next = rbvi_pkg::S_DV;
                end
                else
                begin
                    job_next   = rbvi_pkg::JOB_ACCEL;
                    ret_next   = rbvi_pkg::S_ACCEL;
                    state_next = rbvi_pkg::S_MD_MUL;
                end
            end
            rbvi_pkg::S_DV:
            begin
                if (idx_reg == 2'd3)
                begin
                    idx_next   = 2'd0;
                    vec_next   = rbvi_pkg::VEC_WALK;
                    ret_next   = rbvi_pkg::S_MAXC0;
                    state_next = rbvi_pkg::S_LEN_CLR;
                end
                else
                begin
                    job_next   = rbvi_pkg::JOB_DV;
                    ret_next   = rbvi_pkg::S_AIR;
                    state_next = rbvi_pkg::S_MD_MUL;
                end
            end
            rbvi_pkg::S_AIR:
            begin
                if (status.airborne)
                begin
                    job_next   = rbvi_pkg::JOB_AIR;
                    ret_next   = rbvi_pkg::S_WADD;
                    state_next = rbvi_pkg::S_MD_MUL;
                end
                else
                    state_next = rbvi_pkg::S_WADD;
            end
            rbvi_pkg::S_WADD:
            begin
                cmd.op     = rbvi_pkg::OP_WADD;
                idx_next   = idx_reg + 2'd1;
                state_next = rbvi_pkg::S_DV;
            end

            rbvi_pkg::S_MAXC0:
                state_next = status.max_walk_hit ? rbvi_pkg::S_MAXC : rbvi_pkg::S_MIN0;
            rbvi_pkg::S_MAXC:
            begin
                if (idx_reg == 2'd3)
                begin
                    idx_next   = 2'd0;
                    state_next = rbvi_pkg::S_MIN0;
                end
                else
                begin
                    job_next   = rbvi_pkg::JOB_MAXC;
                    ret_next   = rbvi_pkg::S_MAXC;
                    state_next = rbvi_pkg::S_MD_MUL;
                end
            end

            rbvi_pkg::S_MIN0:
            begin
                if (status.min_on)
                begin
                    vec_next   = rbvi_pkg::VEC_WALK;
                    ret_next   = rbvi_pkg::S_MIN1;
                    state_next = rbvi_pkg::S_LEN_CLR;
                end
                else
                    state_next = rbvi_pkg::S_FRIC0;
            end
            rbvi_pkg::S_MIN1:
            begin
                if (status.len_lt_ten)
                begin
                    vec_next   = rbvi_pkg::VEC_FORCE;
                    ret_next   = rbvi_pkg::S_MINC;
                    state_next = rbvi_pkg::S_LEN_CLR;
                end
                else
                    state_next = rbvi_pkg::S_FRIC0;
            end
            rbvi_pkg::S_MINC:
            begin
                if (idx_reg == 2'd3)
                begin
                    idx_next   = 2'd0;
                    state_next = rbvi_pkg::S_FRIC0;
                end
                else
                begin
                    job_next   = rbvi_pkg::JOB_MINC;
                    ret_next   = rbvi_pkg::S_MINC;
                    state_next = rbvi_pkg::S_MD_MUL;
                end
            end

            rbvi_pkg::S_FRIC0:
            begin
                if (!status.force_nz)
                begin
                    job_next   = rbvi_pkg::JOB_DEC;
                    ret_next   = rbvi_pkg::S_FRIC1;
                    state_next = rbvi_pkg::S_MD_MUL;
                end
                else
                    state_next = rbvi_pkg::S_GRAV0;
            end
            rbvi_pkg::S_FRIC1:
            begin
                vec_next   = rbvi_pkg::VEC_WALK;
                ret_next   = rbvi_pkg::S_FRIC2;
                state_next = rbvi_pkg::S_LEN_CLR;
            end
            rbvi_pkg::S_FRIC2:
            begin
                // at rest: nothing to slow down
                if (status.len_zero)
                    state_next = rbvi_pkg::S_GRAV0;
                else
                begin
                    cmd.op     = rbvi_pkg::OP_SPD;
                    state_next = rbvi_pkg::S_FRIC;
                end
            end
            rbvi_pkg::S_FRIC:
            begin
                if (idx_reg == 2'd3)
                begin
                    idx_next   = 2'd0;
                    state_next = rbvi_pkg::S_GRAV0;
                end
                else
                begin
                    job_next   = rbvi_pkg::JOB_FRIC;
                    ret_next   = rbvi_pkg::S_FRIC;
                    state_next = rbvi_pkg::S_MD_MUL;
                end
            end

            rbvi_pkg::S_GRAV0:
            begin
                if (status.airborne)
                begin
                    job_next   = rbvi_pkg::JOB_GRAV;
                    ret_next   = rbvi_pkg::S_GRAV1;
                    state_next = rbvi_pkg::S_MD_MUL;
                end
                else
                    state_next = rbvi_pkg::S_FIN;
            end
            rbvi_pkg::S_GRAV1:
            begin
                cmd.op     = rbvi_pkg::OP_GSUB;
                state_next = rbvi_pkg::S_GRAV2;
            end
            rbvi_pkg::S_GRAV2:
            begin
                if (status.fall_cap_on)
                begin
                    vec_next   = rbvi_pkg::VEC_FALL;
                    ret_next   = rbvi_pkg::S_GRAV3;
                    state_next = rbvi_pkg::S_LEN_CLR;
                end
                else
                    state_next = rbvi_pkg::S_FIN;
            end
            rbvi_pkg::S_GRAV3:
                state_next = status.max_fall_hit ? rbvi_pkg::S_FALL : rbvi_pkg::S_FIN;
            rbvi_pkg::S_FALL:
            begin
                if (idx_reg == 2'd3)
                begin
                    idx_next   = 2'd0;
                    state_next = rbvi_pkg::S_FIN;
                end
                else
                begin
                    job_next   = rbvi_pkg::JOB_FALL;
                    ret_next   = rbvi_pkg::S_FALL;
                    state_next = rbvi_pkg::S_MD_MUL;
                end
            end

            rbvi_pkg::S_FIN:
            begin
                cmd.op     = rbvi_pkg::OP_FIN;
                idx_next   = 2'd0;
                state_next = rbvi_pkg::S_POS;
            end
            rbvi_pkg::S_POS:
            begin
                if (idx_reg == 2'd3)
                begin
                    idx_next   = 2'd0;
                    state_next = rbvi_pkg::S_EMIT;
                end
                else
                begin
                    job_next   = rbvi_pkg::JOB_POS;
                    ret_next   = rbvi_pkg::S_POS;
                    state_next = rbvi_pkg::S_MD_MUL;
                end
            end
            rbvi_pkg::S_EMIT:
            begin
                // hold until the output register frees up
                if (!status.out_busy)
                begin
                    cmd.op     = rbvi_pkg::OP_EMIT;
                    state_next = rbvi_pkg::S_IDLE;
                end
            end
            default:
                state_next = rbvi_pkg::S_IDLE;
        endcase
    end

endmodule

/* hdl/rbvi_datapath.sv */
// Datapath: config registers, velocity state, shared multiplier, one-bit-per-cycle
// divider, integer square root and output register. Depends on rbvi_pkg.
module rbvi_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rbvi_pkg::dp_cmd_t    cmd,
    output rbvi_pkg::dp_status_t status,
    input  rbvi_pkg::in_item_t   item,
    input  logic                 cfg_valid,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 result_stall,
    output logic                 result_valid,
    output rbvi_pkg::out_item_t  result
);

    localparam logic [63:0] ONE_Q    = 64'd1 << FRAC_BITS;
    localparam logic [31:0] ONE_FX   = ONE_Q[31:0];
    localparam logic [63:0] TEN_Q    = 64'd10 << FRAC_BITS;
    localparam logic [31:0] TEN_FX   = TEN_Q[31:0];
    localparam logic [63:0] ONE03_Q  = (64'd3 * ONE_Q + 64'd5) / 64'd10;
    localparam logic [31:0] ONE03    = ONE03_Q[31:0];
    localparam logic [30:0] RST_MASS = rbvi_pkg::sat_cfg(ONE_Q);
    localparam logic [30:0] RST_FRIC = rbvi_pkg::sat_cfg(64'd500 << FRAC_BITS);
    localparam logic [30:0] RST_GRAV = rbvi_pkg::sat_cfg(64'd980 << FRAC_BITS);
    localparam logic [30:0] RST_JUMP = rbvi_pkg::sat_cfg(64'd400 << FRAC_BITS);

    // configuration
    logic [30:0] mass_reg, minw_reg, maxw_reg, fric_reg, grav_reg, maxf_reg, jump_reg;
    logic        gen_reg;

    // body state and per-item values
    logic signed [31:0] wv_reg [0:2];
    logic signed [31:0] fv_reg [0:2];
    logic signed [31:0] force_reg [0:2];
    logic signed [31:0] pos_reg [0:2];
    logic signed [31:0] acc_reg [0:2];
    logic signed [31:0] fin_reg [0:2];
    logic [15:0]        dt_reg;
    logic               gnd_reg;
    logic signed [31:0] dv_reg;
    logic [31:0]        dec_reg;

    // arithmetic units
    logic [63:0] prod_reg;
    logic        sign_reg;
    logic [63:0] sum_reg;
    logic [31:0] div_rem_reg;
    logic [63:0] div_quo_reg;
    logic [31:0] div_d_reg;
    logic [6:0]  div_cnt_reg;
    logic [63:0] sq_n_reg, sq_r_reg, sq_b_reg;
    logic [5:0]  sq_cnt_reg;

    logic        out_valid_reg;
    rbvi_pkg::out_item_t out_reg;

    logic signed [31:0] a_sel, vec_val, mul_a, wb_val;
    logic [31:0]        m_sel, d_sel, mag_a, mul_m, len;
    logic [63:0]        prod_c;
    logic [32:0]        rem_sh;
    logic               div_ge;
    logic [31:0]        rem_new;
    logic [63:0]        sq_t;
    logic               sq_ge;
    logic [31:0]        mass_eff;

    assign len      = sq_r_reg[31:0];
    assign mass_eff = (mass_reg == 31'd0) ? 32'd1 : {1'b0, mass_reg};

    always_comb
    begin
        a_sel = force_reg[cmd.idx];
        m_sel = ONE_FX;
        d_sel = len;
        case (cmd.job)
            rbvi_pkg::JOB_ACCEL:
            begin
                a_sel = force_reg[cmd.idx];
                m_sel = ONE_FX;
                d_sel = mass_eff;
            end
            rbvi_pkg::JOB_DV:
            begin
                a_sel = acc_reg[cmd.idx];
                m_sel = {16'd0, dt_reg};
            end
            rbvi_pkg::JOB_AIR:
            begin
                a_sel = dv_reg;
                m_sel = ONE03;
            end
            rbvi_pkg::JOB_MAXC:
            begin
                a_sel = wv_reg[cmd.idx];
                m_sel = {1'b0, maxw_reg};
            end
            rbvi_pkg::JOB_MINC:
            begin
                a_sel = force_reg[cmd.idx];
                m_sel = {1'b0, minw_reg};
            end
            rbvi_pkg::JOB_FRIC:
            begin
                a_sel = wv_reg[cmd.idx];
                m_sel = dec_reg;
            end
            rbvi_pkg::JOB_DEC:
            begin
                a_sel = {1'b0, fric_reg};
                m_sel = {16'd0, dt_reg};
            end
            rbvi_pkg::JOB_GRAV:
            begin
                a_sel = {1'b0, grav_reg};
                m_sel = {16'd0, dt_reg};
            end
            rbvi_pkg::JOB_FALL:
            begin
                a_sel = fv_reg[cmd.idx];
                m_sel = {1'b0, maxf_reg};
            end
            rbvi_pkg::JOB_POS:
            begin
                a_sel = fin_reg[cmd.idx];
                m_sel = {16'd0, dt_reg};
            end
            default:
            begin
                a_sel = force_reg[cmd.idx];
                m_sel = ONE_FX;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.vec)
            rbvi_pkg::VEC_WALK:  vec_val = wv_reg[cmd.idx];
            rbvi_pkg::VEC_FALL:  vec_val = fv_reg[cmd.idx];
            rbvi_pkg::VEC_FORCE: vec_val = force_reg[cmd.idx];
            default:             vec_val = wv_reg[cmd.idx];
        endcase
    end

    assign mul_a  = (cmd.op == rbvi_pkg::OP_SQ) ? vec_val : a_sel;
    assign mag_a  = mul_a[31] ? (~mul_a + 32'd1) : mul_a;
    assign mul_m  = (cmd.op == rbvi_pkg::OP_SQ) ? mag_a : m_sel;
    assign prod_c = 64'(mag_a) * 64'(mul_m);

    assign wb_val = rbvi_pkg::mag_to_s32(sign_reg, div_quo_reg);

    // restoring divider step
    assign rem_sh  = {div_rem_reg, div_quo_reg[63]};
    assign div_ge  = (rem_sh >= {1'b0, div_d_reg});
    assign rem_new = div_ge ? 32'(rem_sh - {1'b0, div_d_reg}) : rem_sh[31:0];

    // square root step
    assign sq_t  = sq_r_reg + sq_b_reg;
    assign sq_ge = (sq_n_reg >= sq_t);

    always_comb
    begin
        status.airborne     = gen_reg && !gnd_reg;
        status.acc_nz       = (acc_reg[0] != 32'sd0) || (acc_reg[1] != 32'sd0)
                              || (acc_reg[2] != 32'sd0);
        status.force_nz     = (force_reg[0] != 32'sd0) || (force_reg[1] != 32'sd0)
                              || (force_reg[2] != 32'sd0);
        status.min_on       = (minw_reg != 31'd0) && status.acc_nz;
        status.len_zero     = (len == 32'd0);
        status.len_lt_ten   = (len < TEN_FX);
        status.max_walk_hit = (maxw_reg != 31'd0) && ({1'b0, maxw_reg} < len);
        status.fall_cap_on  = fv_reg[1][31] && (maxf_reg != 31'd0);
        status.max_fall_hit = ({1'b0, maxf_reg} < len);
        status.div_busy     = (div_cnt_reg != 7'd0);
        status.sqrt_busy    = (sq_cnt_reg != 6'd0);
        status.out_busy     = out_valid_reg && result_stall;
    end

    // control state, configuration and body velocities
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass_reg      <= RST_MASS;
            minw_reg      <= 31'd0;
            maxw_reg      <= 31'd0;
            fric_reg      <= RST_FRIC;
            grav_reg      <= RST_GRAV;
            maxf_reg      <= 31'd0;
            jump_reg      <= RST_JUMP;
            gen_reg       <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                wv_reg[i] <= 32'sd0;
                fv_reg[i] <= 32'sd0;
            end
            div_cnt_reg   <= 7'd0;
            sq_cnt_reg    <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (rbvi_pkg::cfg_reg_t'(cfg_index))
                    rbvi_pkg::REG_BODY_MASS:      mass_reg <= cfg_data[30:0];
                    rbvi_pkg::REG_MIN_WALK_SPEED: minw_reg <= cfg_data[30:0];
                    rbvi_pkg::REG_MAX_WALK_SPEED: maxw_reg <= cfg_data[30:0];
                    rbvi_pkg::REG_FRICTION_DECEL: fric_reg <= cfg_data[30:0];
                    rbvi_pkg::REG_GRAVITY_ACCEL:  grav_reg <= cfg_data[30:0];
                    rbvi_pkg::REG_MAX_FALL_SPEED: maxf_reg <= cfg_data[30:0];
                    rbvi_pkg::REG_JUMP_SPEED:     jump_reg <= cfg_data[30:0];
                    rbvi_pkg::REG_GRAVITY_ENABLE: gen_reg  <= cfg_data[0];
                    default: ;
                endcase
            end

            if (out_valid_reg && !result_stall)
                out_valid_reg <= 1'b0;

            if (div_cnt_reg != 7'd0)
                div_cnt_reg <= div_cnt_reg - 7'd1;
            if (sq_cnt_reg != 6'd0)
                sq_cnt_reg <= sq_cnt_reg - 6'd1;

            case (cmd.op)
                rbvi_pkg::OP_JUMP:
                    fv_reg[1] <= rbvi_pkg::sat_add(fv_reg[1], {1'b0, jump_reg});
                rbvi_pkg::OP_DIV_START:
                    div_cnt_reg <= 7'd64;
                rbvi_pkg::OP_SQRT_START:
                    sq_cnt_reg <= 6'd32;
                rbvi_pkg::OP_WADD:
                    wv_reg[cmd.idx] <= rbvi_pkg::sat_add(wv_reg[cmd.idx], dv_reg);
                rbvi_pkg::OP_GSUB:
                    fv_reg[1] <= rbvi_pkg::sat_add(fv_reg[1], -$signed(dec_reg));
                rbvi_pkg::OP_WB:
                begin
                    case (cmd.job)
                        rbvi_pkg::JOB_MAXC, rbvi_pkg::JOB_MINC, rbvi_pkg::JOB_FRIC:
                            wv_reg[cmd.idx] <= wb_val;
                        rbvi_pkg::JOB_FALL:
                            fv_reg[cmd.idx] <= wb_val;
                        default: ;
                    endcase
                end
                rbvi_pkg::OP_EMIT:
                    out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // working values
    always_ff @(posedge clk)
    begin
        if (div_cnt_reg != 7'd0)
        begin
            div_rem_reg <= rem_new;
            div_quo_reg <= {div_quo_reg[62:0], div_ge};
        end
        if (sq_cnt_reg != 6'd0)
        begin
            if (sq_ge)
            begin
                sq_n_reg <= sq_n_reg - sq_t;
                sq_r_reg <= (sq_r_reg >> 1) + sq_b_reg;
            end
            else
                sq_r_reg <= sq_r_reg >> 1;
            sq_b_reg <= sq_b_reg >> 2;
        end

        case (cmd.op)
            rbvi_pkg::OP_LOAD:
            begin
                force_reg[0] <= item.force_x;
                force_reg[1] <= item.force_y;
                force_reg[2] <= item.force_z;
                pos_reg[0]   <= item.pos_in_x;
                pos_reg[1]   <= item.pos_in_y;
                pos_reg[2]   <= item.pos_in_z;
                dt_reg       <= item.frame_time;
                gnd_reg      <= item.on_ground;
            end
            rbvi_pkg::OP_MUL:
            begin
                prod_reg <= prod_c;
                sign_reg <= a_sel[31];
            end
            rbvi_pkg::OP_SHIFT:
            begin
                if (cmd.job == rbvi_pkg::JOB_AIR)
                    div_quo_reg <= prod_reg >> FRAC_BITS;
                else
                    div_quo_reg <= prod_reg >> rbvi_pkg::DT_BITS;
            end
            rbvi_pkg::OP_DIV_START:
            begin
                div_quo_reg <= prod_reg;
                div_rem_reg <= 32'd0;
                div_d_reg   <= d_sel;
            end
            rbvi_pkg::OP_WB:
            begin
                case (cmd.job)
                    rbvi_pkg::JOB_ACCEL:              acc_reg[cmd.idx] <= wb_val;
                    rbvi_pkg::JOB_DV, rbvi_pkg::JOB_AIR: dv_reg <= wb_val;
                    rbvi_pkg::JOB_DEC, rbvi_pkg::JOB_GRAV: dec_reg <= wb_val;
                    rbvi_pkg::JOB_POS:
                        pos_reg[cmd.idx] <= rbvi_pkg::sat_add(pos_reg[cmd.idx], wb_val);
                    default: ;
                endcase
            end
            rbvi_pkg::OP_SPD:
                dec_reg <= (len > dec_reg) ? (len - dec_reg) : 32'd0;
            rbvi_pkg::OP_FIN:
            begin
                for (int i = 0; i < 3; i++)
                    fin_reg[i] <= rbvi_pkg::sat_add(wv_reg[i], fv_reg[i]);
            end
            rbvi_pkg::OP_SUM_CLR:
                sum_reg <= 64'd0;
            rbvi_pkg::OP_SQ:
                prod_reg <= prod_c;
            rbvi_pkg::OP_SUM_ADD:
                sum_reg <= sum_reg + prod_reg;
            rbvi_pkg::OP_SQRT_START:
            begin
                sq_n_reg <= sum_reg;
                sq_r_reg <= 64'd0;
                sq_b_reg <= 64'd1 << 62;
            end
            rbvi_pkg::OP_EMIT:
            begin
                out_reg.pos_out_x   <= pos_reg[0];
                out_reg.pos_out_y   <= pos_reg[1];
                out_reg.pos_out_z   <= pos_reg[2];
                out_reg.total_vel_x <= fin_reg[0];
                out_reg.total_vel_y <= fin_reg[1];
                out_reg.total_vel_z <= fin_reg[2];
            end
            default: ;
        endcase
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

/* hdl/rbvi_checker.sv */
// Port-level checks for the integrator, bound to the top level.
// Depends on rbvi_pkg and rigid_body_velocity_integrator.
module rbvi_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_stall,
    input rbvi_pkg::in_item_t  item,
    input logic                result_valid,
    input logic                result_stall,
    input rbvi_pkg::out_item_t result
);

    // a stalled result beat stays
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result beat dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result payload changed while stalled");

    // a tick occupies the block
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && !item.mode |=> item_stall)
        else $error("tick beat did not start work");

    // a jump finishes at once
    a_jump_quick: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.mode |=> !item_stall)
        else $error("jump beat held the input");

endmodule

bind rigid_body_velocity_integrator rbvi_checker u_rbvi_checker (.*);
